/* rtl/flip_completion_tracker_defines.svh */
// Assertion macros shared by the flip completion tracker RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef FLIP_COMPLETION_TRACKER_DEFINES_SVH
`define FLIP_COMPLETION_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define FCT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define FCT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fct_pkg.sv */
// Package for the flip completion tracker: request codes, field widths and payload structs.
// Depends on nothing; used by flip_completion_tracker.
`default_nettype none

package fct_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int REQ_W     = 2;
    localparam int COOKIE_W  = 32;
    localparam int BUF_W     = 4;
    localparam int CONTENT_W = 32;
    localparam int VSEQ_W    = 32;

    localparam logic [REQ_W-1:0] REQ_SUBMIT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EVENT  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_BLOCK  = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]     req_type;
        logic [COOKIE_W-1:0]  cookie;
        logic [BUF_W-1:0]     buf_slot;
        logic [CONTENT_W-1:0] content_seq;
        logic [VSEQ_W-1:0]    vblank_seq;
    } fct_in_t;

    typedef struct packed {
        logic [BUF_W-1:0]     latched_buffer;
        logic [CONTENT_W-1:0] latched_content;
        logic                 latched_known;
        logic                 ack_valid;
        logic                 prev_valid;
        logic [BUF_W-1:0]     prev_buffer;
        logic [CONTENT_W-1:0] prev_content;
        logic                 prev_count_known;
        logic [VSEQ_W-1:0]    prev_extra_scans;
        logic                 prev_content_resolved;
        logic                 last;
    } fct_out_t;

endpackage

`default_nettype wire

/* rtl/flip_completion_tracker.sv */
// Flip completion tracker top level: pending flip queue, sequencer and shared subtractor.
// Depends on fct_pkg and flip_completion_tracker_defines.svh.
`default_nettype none
`include "flip_completion_tracker_defines.svh"

// The tracker keeps a queue of up to QUEUE_DEPTH submitted display flips and turns
// completion evidence into one result per completed flip. A submit request queues
// its flip, or is dropped when the queue is full, and gives no result. A blocking
// request goes from idle to ST_OUT and gives one confirmed result there once the
// output register is free. A completion event walks the queue from the oldest
// entry, reading (ST_SCAN_RD) and comparing (ST_SCAN_CMP) each entry in turn, until
// the cookie matches; then it walks the entries up to the match again through
// ST_EMIT_RD, ST_EMIT_CHK, ST_MIN (only when the vblank gap is resolved) and ST_OUT,
// emitting older flips as coalesced and the match as confirmed. An unknown cookie
// flushes the whole queue as coalesced. This stepping is set by the single-read-port
// queue memory, whose read data is registered, and by one 32-bit subtractor that
// serves the cookie compare, the vblank gap and the minimum gap compare in turn.
// The block takes no new request while a request is in progress, but the last
// result sits in an output register, so the next request can be accepted while that
// result still waits for m_ready. The queue storage needs no clearing after reset:
// only occupied entries are ever read.
module flip_completion_tracker
    import fct_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire fct_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output fct_out_t      m_data
);

    // Index, count and tail-sum widths all follow from the queue depth.
    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = $clog2(2 * QUEUE_DEPTH);

    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [IW-1:0] LAST_SLOT = IW'(QUEUE_DEPTH - 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN_RD  = 3'd1;
    localparam logic [2:0] ST_SCAN_CMP = 3'd2;
    localparam logic [2:0] ST_EMIT_RD  = 3'd3;
    localparam logic [2:0] ST_EMIT_CHK = 3'd4;
    localparam logic [2:0] ST_MIN      = 3'd5;
    localparam logic [2:0] ST_OUT      = 3'd6;

    // Queue storage. It has one write port (submit) and one registered read port.
    logic [COOKIE_W-1:0]  mem_cookie  [QUEUE_DEPTH];
    logic [BUF_W-1:0]     mem_buffer  [QUEUE_DEPTH];
    logic [CONTENT_W-1:0] mem_content [QUEUE_DEPTH];

    logic [COOKIE_W-1:0]  rd_cookie_reg;
    logic [BUF_W-1:0]     rd_buffer_reg;
    logic [CONTENT_W-1:0] rd_content_reg;

    logic                 rd_en;
    logic                 wr_en;
    logic [IW-1:0]        tail;
    logic [SW-1:0]        tail_sum;

    // Sequencer and queue control state.
    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [IW-1:0]        head_reg, head_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [IW-1:0]        slot_reg, slot_next;
    logic [CW-1:0]        match_reg, match_next;
    logic                 found_reg, found_next;
    logic                 blk_reg, blk_next;
    fct_in_t              req_reg, req_next;

    // Resolution scratch values for the result under construction.
    logic                 resolved_reg, resolved_next;
    logic [VSEQ_W-1:0]    extra_reg, extra_next;
    logic [VSEQ_W-1:0]    gap_reg, gap_next;

    // History of the previous completed flip and the learned minimum gap.
    logic                 prev_flip_valid_reg, prev_flip_valid_next;
    logic [BUF_W-1:0]     prev_flip_buffer_reg, prev_flip_buffer_next;
    logic [CONTENT_W-1:0] prev_flip_content_reg, prev_flip_content_next;
    logic [VSEQ_W-1:0]    prev_event_seq_reg, prev_event_seq_next;
    logic                 have_event_seq_reg, have_event_seq_next;
    logic                 prev_anchored_reg, prev_anchored_next;
    logic [VSEQ_W-1:0]    min_gap_reg, min_gap_next;

    // Output register.
    logic                 m_valid_reg, m_valid_next;
    fct_out_t             out_reg, out_next;

    // Shared subtractor: a minus b with borrow and zero flags.
    logic [VSEQ_W-1:0]    op_a;
    logic [VSEQ_W-1:0]    op_b;
    logic [VSEQ_W:0]      diff;
    logic                 borrow;
    logic                 diff_zero;

    logic                 out_free;
    logic                 is_event;
    logic                 is_last;
    logic [IW-1:0]        slot_inc;
    logic [BUF_W-1:0]     emit_buffer;
    logic [CONTENT_W-1:0] emit_content;
    logic                 emit_known;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;
    assign out_free = !m_valid_reg || m_ready;

    // The tail slot is head plus count, which stays below twice the depth.
    assign tail_sum = SW'(head_reg) + SW'(count_reg);
    assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? IW'(tail_sum - SW'(QUEUE_DEPTH))
                                                     : IW'(tail_sum);
    assign slot_inc = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;

    // The matched entry is the only one confirmed by the event; it is also the last.
    assign is_event = found_reg && (idx_reg == match_reg);
    assign is_last  = blk_reg || (found_reg ? (idx_reg == match_reg)
                                            : (idx_reg == count_reg - 1'b1));

    assign emit_buffer  = blk_reg ? req_reg.buf_slot : rd_buffer_reg;
    assign emit_content = blk_reg ? req_reg.content_seq : rd_content_reg;
    assign emit_known   = blk_reg || is_event;

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            ST_SCAN_CMP: begin
                op_a = rd_cookie_reg;
                op_b = req_reg.cookie;
            end
            ST_EMIT_CHK: begin
                op_a = req_reg.vblank_seq;
                op_b = prev_event_seq_reg;
            end
            ST_MIN: begin
                op_a = gap_reg;
                op_b = min_gap_reg;
            end
            default: begin
            end
        endcase
    end

    assign diff      = {1'b0, op_a} - {1'b0, op_b};
    assign borrow    = diff[VSEQ_W];
    assign diff_zero = (diff[VSEQ_W-1:0] == '0);

    always_comb begin
        state_next             = state_reg;
        count_next             = count_reg;
        head_next              = head_reg;
        idx_next               = idx_reg;
        slot_next              = slot_reg;
        match_next             = match_reg;
        found_next             = found_reg;
        blk_next               = blk_reg;
        req_next               = req_reg;
        resolved_next          = resolved_reg;
        extra_next             = extra_reg;
        gap_next               = gap_reg;
        prev_flip_valid_next   = prev_flip_valid_reg;
        prev_flip_buffer_next  = prev_flip_buffer_reg;
        prev_flip_content_next = prev_flip_content_reg;
        prev_event_seq_next    = prev_event_seq_reg;
        have_event_seq_next    = have_event_seq_reg;
        prev_anchored_next     = prev_anchored_reg;
        min_gap_next           = min_gap_reg;
        m_valid_next           = m_valid_reg && !m_ready;
        out_next               = out_reg;
        rd_en                  = 1'b0;
        wr_en                  = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next = s_data;
                    case (s_data.req_type)
                        REQ_SUBMIT: begin
                            // A full queue silently drops the submit.
                            if (count_reg < DEPTH_C) begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        REQ_EVENT: begin
                            blk_next = 1'b0;
                            if (count_reg == '0) begin
                                head_next = '0;
                            end else begin
                                idx_next   = '0;
                                slot_next  = head_reg;
                                state_next = ST_SCAN_RD;
                            end
                        end
                        REQ_BLOCK: begin
                            blk_next      = 1'b1;
                            resolved_next = prev_flip_valid_reg;
                            extra_next    = '0;
                            state_next    = ST_OUT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN_RD: begin
                rd_en      = 1'b1;
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (diff_zero) begin
                    found_next = 1'b1;
                    match_next = idx_reg;
                    idx_next   = '0;
                    slot_next  = head_reg;
                    state_next = ST_EMIT_RD;
                end else if (idx_reg == count_reg - 1'b1) begin
                    // No entry matches: every pending flip is flushed as coalesced.
                    found_next = 1'b0;
                    match_next = count_reg;
                    idx_next   = '0;
                    slot_next  = head_reg;
                    state_next = ST_EMIT_RD;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    slot_next  = slot_inc;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_EMIT_RD: begin
                rd_en      = 1'b1;
                state_next = ST_EMIT_CHK;
            end
            ST_EMIT_CHK: begin
                // The vblank gap is measured only between two event-anchored completions.
                if (is_event && prev_flip_valid_reg && prev_anchored_reg &&
                    have_event_seq_reg && !borrow && !diff_zero) begin
                    gap_next   = diff[VSEQ_W-1:0];
                    state_next = ST_MIN;
                end else begin
                    resolved_next = 1'b0;
                    extra_next    = '0;
                    state_next    = ST_OUT;
                end
            end
            ST_MIN: begin
                resolved_next = 1'b1;
                if ((min_gap_reg == '0) || borrow) begin
                    min_gap_next = gap_reg;
                    extra_next   = '0;
                end else begin
                    extra_next = diff[VSEQ_W-1:0];
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next                   = 1'b1;
                    out_next.latched_buffer        = emit_buffer;
                    out_next.latched_content       = emit_content;
                    out_next.latched_known         = emit_known;
                    out_next.ack_valid             = emit_known && (emit_content != '0);
                    out_next.prev_valid            = prev_flip_valid_reg;
                    out_next.prev_buffer           = prev_flip_valid_reg ?
                                                     prev_flip_buffer_reg : '0;
                    out_next.prev_content          = prev_flip_valid_reg ?
                                                     prev_flip_content_reg : '0;
                    out_next.prev_count_known      = resolved_reg;
                    out_next.prev_extra_scans      = resolved_reg ? extra_reg : '0;
                    out_next.prev_content_resolved = resolved_reg &&
                                                     (prev_flip_content_reg != '0);
                    out_next.last                  = is_last;

                    // This flip becomes the previous plane for the next completion.
                    if (!blk_reg && is_event) begin
                        prev_event_seq_next = req_reg.vblank_seq;
                        have_event_seq_next = 1'b1;
                    end
                    prev_flip_valid_next   = 1'b1;
                    prev_flip_buffer_next  = emit_buffer;
                    prev_flip_content_next = emit_content;
                    prev_anchored_next     = !blk_reg && is_event;

                    if (is_last) begin
                        if (!blk_reg) begin
                            if (found_reg) begin
                                head_next  = slot_inc;
                                count_next = count_reg - (match_reg + 1'b1);
                            end else begin
                                head_next  = '0;
                                count_next = '0;
                            end
                        end
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        slot_next  = slot_inc;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_cookie[tail]  <= s_data.cookie;
            mem_buffer[tail]  <= s_data.buf_slot;
            mem_content[tail] <= s_data.content_seq;
        end
        if (rd_en) begin
            rd_cookie_reg  <= mem_cookie[slot_reg];
            rd_buffer_reg  <= mem_buffer[slot_reg];
            rd_content_reg <= mem_content[slot_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg             <= ST_IDLE;
            count_reg             <= '0;
            head_reg              <= '0;
            idx_reg               <= '0;
            slot_reg              <= '0;
            match_reg             <= '0;
            found_reg             <= 1'b0;
            blk_reg               <= 1'b0;
            resolved_reg          <= 1'b0;
            prev_flip_valid_reg   <= 1'b0;
            prev_flip_buffer_reg  <= '0;
            prev_flip_content_reg <= '0;
            prev_event_seq_reg    <= '0;
            have_event_seq_reg    <= 1'b0;
            prev_anchored_reg     <= 1'b0;
            min_gap_reg           <= '0;
            m_valid_reg           <= 1'b0;
        end else begin
            state_reg             <= state_next;
            count_reg             <= count_next;
            head_reg              <= head_next;
            idx_reg               <= idx_next;
            slot_reg              <= slot_next;
            match_reg             <= match_next;
            found_reg             <= found_next;
            blk_reg               <= blk_next;
            resolved_reg          <= resolved_next;
            prev_flip_valid_reg   <= prev_flip_valid_next;
            prev_flip_buffer_reg  <= prev_flip_buffer_next;
            prev_flip_content_reg <= prev_flip_content_next;
            prev_event_seq_reg    <= prev_event_seq_next;
            have_event_seq_reg    <= have_event_seq_next;
            prev_anchored_reg     <= prev_anchored_next;
            min_gap_reg           <= min_gap_next;
            m_valid_reg           <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        extra_reg <= extra_next;
        gap_reg   <= gap_next;
        out_reg   <= out_next;
    end

    // The queue never holds more flips than it has slots.
    `FCT_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= DEPTH_C,
        "pending flip count exceeds queue depth")

    // The search only compares occupied entries.
    `FCT_ASSERT_NOW(a_scan_in_range, aclk, aresetn, state_reg == ST_SCAN_CMP,
        idx_reg < count_reg, "queue search ran past the occupied entries")

    // An accepted submit to a queue with room grows the queue by one.
    `FCT_ASSERT_NEXT(a_submit_grows, aclk, aresetn,
        s_valid && s_ready && (s_data.req_type == REQ_SUBMIT) && (count_reg < DEPTH_C),
        count_reg == $past(count_reg) + 1'b1, "accepted submit did not enter the queue")

    // A resolved event completion always has a learned minimum gap behind it.
    `FCT_ASSERT_NOW(a_min_learned, aclk, aresetn,
        (state_reg == ST_OUT) && out_free && !blk_reg && is_event && resolved_reg,
        min_gap_reg != '0, "resolved event result without a learned minimum gap")

    // The final result of a request hands control back for the next request.
    `FCT_ASSERT_NEXT(a_last_frees, aclk, aresetn,
        (state_reg == ST_OUT) && out_free && is_last,
        s_ready && m_valid && m_data.last, "last result did not end the request")

endmodule

`default_nettype wire
